// File: hw/rtl/rtm_pkg.sv
// rtm_pkg: shared constants, codes and types of the rank topology mapper.
// Used by rtm_div and rank_topology_mapper; depends on nothing.
package rtm_pkg;

	// default parameter values
	localparam int RTM_RANK_BITS = 24;
	localparam int RTM_RACK_BITS = 16;

	// configuration register widths
	localparam int SIZE_W     = 8;   // rack size, tray size
	localparam int RC_W       = 16;  // rack_count
	localparam int SC_W       = 24;  // spare_count
	localparam int TOTAL_W    = SIZE_W + RC_W;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	// compose operand widths
	localparam int TRAY_W = 8;
	localparam int SLOT_W = 8;

	// configuration reset values
	localparam logic [SIZE_W-1:0] GPR_RESET = SIZE_W'(72);
	localparam logic [SIZE_W-1:0] GPT_RESET = SIZE_W'(4);
	localparam logic [RC_W-1:0]   RC_RESET  = RC_W'(1);
	localparam logic [SC_W-1:0]   SC_RESET  = '0;

	typedef enum logic [1:0] {
		OP_DECOMPOSE = 2'd0,
		OP_COMPOSE   = 2'd1,
		OP_SAME_RACK = 2'd2,
		OP_SPARE     = 2'd3
	} rtm_op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_CFG_ERR = 2'd1,
		STAT_REQ_ERR = 2'd2,
		STAT_RSVD    = 2'd3
	} rtm_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RACK_SIZE   = 2'd0,
		CFG_TRAY_SIZE   = 2'd1,
		CFG_RACK_COUNT  = 2'd2,
		CFG_SPARE_COUNT = 2'd3
	} rtm_cfg_idx_t;

	// divider launch control
	typedef struct packed {
		logic start;   // load operands and run
		logic narrow;  // dividend is only SIZE_W bits wide
	} rtm_div_ctl_t;

endpackage

// File: hw/rtl/rank_topology_mapper.sv
// rank_topology_mapper: top level, config registers, sequencer, shared multiplier.
// Depends on rtm_pkg and rtm_div.
//
// Maps cluster ranks to rack / tray / slot positions using sizes held in four
// config registers. Pulse start while busy is low to hand in one item; busy
// stays high until the cycle the result appears. done is high for exactly that
// one cycle, and the result stays on the output ports until the next result.
// The receiver cannot stall the block, so done must be sampled when it fires.
// Every item first checks the config: a zero size or rack count gives status 1
// in the cycle after start is taken (busy never rises); otherwise rack size
// modulo tray size is taken on the shared divider in a short pass over the
// SIZE_W quotient bits, and the check state S_CHK finishes the check, where a
// bad tray size or spare count answers. All divisions run on one restoring
// divider that retires one quotient bit a cycle. Decompose and same-rack take
// two full-width divisions. Spare select adds a range check state, and the
// multiplier states S_NX and S_NC when the first spare lies in the rack of
// rank a; a refused request answers from the range check. Compose needs no
// division, only the shared multiplier. Config registers may be written only
// while busy is low and no done is pending.
module rank_topology_mapper import rtm_pkg::*; #(
	parameter int RANK_BITS = RTM_RANK_BITS,
	parameter int RACK_BITS = RTM_RACK_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [RANK_BITS-1:0]  rank_a,
	input  logic [RANK_BITS-1:0]  rank_b,
	input  logic [RACK_BITS-1:0]  rack_index,
	input  logic [TRAY_W-1:0]     tray_index,
	input  logic [SLOT_W-1:0]     slot_index,
	// result side
	output logic                  done,
	output logic [1:0]            status,
	output logic [RANK_BITS-1:0]  rank_out,
	output logic [RACK_BITS-1:0]  rack_out,
	output logic [SIZE_W-1:0]     slot_in_rack,
	output logic [SIZE_W-1:0]     tray_out,
	output logic [SIZE_W-1:0]     slot_in_tray,
	output logic                  same_rack
);

	// divider must hold both a rank and the cluster total
	localparam int DIV_W = (RANK_BITS > TOTAL_W) ? RANK_BITS : TOTAL_W;
	localparam int MUL_W = DIV_W + SIZE_W;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_CFG  = 11'b000_0000_0010,  // gpr % gpt on the divider
		S_CHK  = 11'b000_0000_0100,  // finish config check
		S_SPR  = 11'b000_0000_1000,  // spare request range check
		S_D1   = 11'b000_0001_0000,  // first division
		S_D2   = 11'b000_0010_0000,  // second division
		S_C1   = 11'b000_0100_0000,  // compose: rack * gpr
		S_C2   = 11'b000_1000_0000,  // compose: tray * gpt
		S_C3   = 11'b001_0000_0000,  // compose: final sum
		S_NX   = 11'b010_0000_0000,  // spare: start of next rack
		S_NC   = 11'b100_0000_0000   // spare: pick
	} state_t;

	typedef struct packed {
		rtm_status_t          status;
		logic [RANK_BITS-1:0] rank;
		logic [RACK_BITS-1:0] rack;
		logic [SIZE_W-1:0]    sir;
		logic [SIZE_W-1:0]    tray;
		logic [SIZE_W-1:0]    sit;
		logic                 same;
	} res_t;

	// config registers
	logic [SIZE_W-1:0] gpr_q;
	logic [SIZE_W-1:0] gpt_q;
	logic [RC_W-1:0]   rc_q;
	logic [SC_W-1:0]   sc_q;

	// latched item
	rtm_op_t              op_q;
	logic [RANK_BITS-1:0] ra_q;
	logic [RANK_BITS-1:0] rb_q;
	logic [RACK_BITS-1:0] rack_q;
	logic [TRAY_W-1:0]    tray_q;
	logic [SLOT_W-1:0]    slot_q;

	// working registers
	state_t            state_q, state_d;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] world_q;
	logic [DIV_W-1:0]   q1_q;
	logic [SIZE_W-1:0]  r1_q;
	logic [MUL_W-1:0]   mul_q;
	logic [MUL_W-1:0]   acc_q;

	// result registers
	logic done_q;
	res_t res_q, res_d;
	logic fin;

	// shared divider hookup
	rtm_div_ctl_t      div_ctl;
	logic [DIV_W-1:0]  div_a;
	logic [SIZE_W-1:0] div_b;
	logic              div_done;
	logic [DIV_W-1:0]  div_q;
	logic [SIZE_W-1:0] div_r;

	// shared multiplier operands
	logic [DIV_W-1:0]  mul_a;
	logic [SIZE_W-1:0] mul_b;

	logic accept;
	logic size_zero;

	assign accept    = start && (state_q == S_IDLE);
	assign size_zero = (gpr_q == '0) || (gpt_q == '0) || (rc_q == '0);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpr_q <= GPR_RESET;
			gpt_q <= GPT_RESET;
			rc_q  <= RC_RESET;
			sc_q  <= SC_RESET;
		end else if (cfg_we) begin
			unique case (rtm_cfg_idx_t'(cfg_index))
				CFG_RACK_SIZE:   gpr_q <= cfg_data[SIZE_W-1:0];
				CFG_TRAY_SIZE:   gpt_q <= cfg_data[SIZE_W-1:0];
				CFG_RACK_COUNT:  rc_q  <= cfg_data[RC_W-1:0];
				CFG_SPARE_COUNT: sc_q  <= cfg_data[SC_W-1:0];
			endcase
		end
	end

	// multiplier operand select; result always registered
	always_comb begin
		unique case (state_q)
			S_C1: begin
				mul_a = DIV_W'(rack_q);
				mul_b = gpr_q;
			end
			S_C2: begin
				mul_a = DIV_W'(tray_q);
				mul_b = gpt_q;
			end
			S_NX: begin
				mul_a = q1_q + 1'b1;
				mul_b = gpr_q;
			end
			default: begin
				// all other states, idle and check included: cluster total
				mul_a = DIV_W'(rc_q);
				mul_b = gpr_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
	end

	// sequencer
	always_comb begin
		state_d        = state_q;
		fin            = 1'b0;
		res_d          = '0;
		res_d.status   = STAT_OK;
		div_ctl.start  = 1'b0;
		div_ctl.narrow = 1'b0;
		div_a          = DIV_W'(ra_q);
		div_b          = gpr_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (size_zero) begin
						fin          = 1'b1;
						res_d.status = STAT_CFG_ERR;
					end else begin
						div_ctl.start  = 1'b1;
						div_ctl.narrow = 1'b1;
						div_a          = DIV_W'(gpr_q);
						div_b          = gpt_q;
						state_d        = S_CFG;
					end
				end
			end
			S_CFG: begin
				if (div_done) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				// tray size must divide rack size, spares below the total
				if ((r1_q != '0) || (sc_q >= total_q)) begin
					fin          = 1'b1;
					res_d.status = STAT_CFG_ERR;
					state_d      = S_IDLE;
				end else begin
					unique case (op_q)
						OP_DECOMPOSE, OP_SAME_RACK: begin
							div_ctl.start = 1'b1;
							state_d       = S_D1;
						end
						OP_COMPOSE: state_d = S_C1;
						OP_SPARE:   state_d = S_SPR;
					endcase
				end
			end
			S_SPR: begin
				if ((sc_q == '0) || (DIV_W'(ra_q) >= DIV_W'(world_q))) begin
					fin          = 1'b1;
					res_d.status = STAT_REQ_ERR;
					state_d      = S_IDLE;
				end else begin
					div_ctl.start = 1'b1;
					state_d       = S_D1;
				end
			end
			S_D1: begin
				if (div_done) begin
					div_ctl.start = 1'b1;
					state_d       = S_D2;
					unique case (op_q)
						OP_DECOMPOSE: begin
							div_a = DIV_W'(div_r);
							div_b = gpt_q;
						end
						OP_SAME_RACK: div_a = DIV_W'(rb_q);
						OP_SPARE:     div_a = DIV_W'(world_q);
						OP_COMPOSE:   div_a = DIV_W'(ra_q);
					endcase
				end
			end
			S_D2: begin
				if (div_done) begin
					state_d = S_IDLE;
					unique case (op_q)
						OP_DECOMPOSE: begin
							fin        = 1'b1;
							res_d.rank = ra_q;
							res_d.rack = RACK_BITS'(q1_q);
							res_d.sir  = r1_q;
							res_d.tray = div_q[SIZE_W-1:0];
							res_d.sit  = div_r;
						end
						OP_SAME_RACK: begin
							fin        = 1'b1;
							res_d.rank = ra_q;
							res_d.same = (q1_q == div_q);
						end
						OP_SPARE: begin
							// first spare lies outside the rack of rank a: answer the first spare
							if (div_q != q1_q) begin
								fin        = 1'b1;
								res_d.rank = RANK_BITS'(world_q);
							end else begin
								state_d = S_NX;
							end
						end
						OP_COMPOSE: state_d = S_IDLE;
					endcase
				end
			end
			S_C1: state_d = S_C2;
			S_C2: state_d = S_C3;
			S_C3: begin
				fin        = 1'b1;
				res_d.rank = RANK_BITS'(acc_q + mul_q);
				state_d    = S_IDLE;
			end
			S_NX: state_d = S_NC;
			S_NC: begin
				// first rank of the next rack if it exists, else first spare
				fin        = 1'b1;
				res_d.rank = (mul_q < MUL_W'(total_q)) ? RANK_BITS'(mul_q)
				                                         : RANK_BITS'(world_q);
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	// item latch, working registers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= rtm_op_t'(op);
			ra_q   <= rank_a;
			rb_q   <= rank_b;
			rack_q <= rack_index;
			tray_q <= tray_index;
			slot_q <= slot_index;
		end
		if (state_q == S_CFG) begin
			total_q <= mul_q[TOTAL_W-1:0];
			if (div_done) begin
				r1_q <= div_r;
			end
		end
		if (state_q == S_CHK) begin
			world_q <= total_q - TOTAL_W'(sc_q);
		end
		if ((state_q == S_D1) && div_done) begin
			q1_q <= div_q;
			r1_q <= div_r;
		end
		if (state_q == S_C2) begin
			acc_q <= mul_q + MUL_W'(slot_q);
		end
		if (fin) begin
			res_q <= res_d;
		end
	end

	rtm_div #(
		.W(DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = res_q.status;
	assign rank_out     = res_q.rank;
	assign rack_out     = res_q.rack;
	assign slot_in_rack = res_q.sir;
	assign tray_out     = res_q.tray;
	assign slot_in_tray = res_q.sit;
	assign same_rack    = res_q.same;

endmodule

// File: hw/rtl/rtm_div.sv
// rtm_div: restoring divider, one quotient bit per cycle, 8-bit divisor.
// Depends on rtm_pkg (SIZE_W, rtm_div_ctl_t).
module rtm_div import rtm_pkg::*; #(
	parameter int W = RTM_RANK_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rtm_div_ctl_t      ctl,
	input  logic [W-1:0]      dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [SIZE_W-1:0] remainder
);

	localparam int CW = $clog2(W);

	logic [SIZE_W-1:0] rem_q;
	logic [W-1:0]      quo_q;
	logic [SIZE_W-1:0] dsr_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;

	logic [SIZE_W:0]   shifted;
	logic [SIZE_W+1:0] trial;
	logic              neg;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
	assign neg     = trial[SIZE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				// narrow: only the top SIZE_W bits hold the dividend
				cnt_q <= ctl.narrow ? CW'(W - SIZE_W) : '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= ctl.narrow ? {dividend[SIZE_W-1:0], {(W-SIZE_W){1'b0}}} : dividend;
		end else if (run_q) begin
			rem_q <= neg ? shifted[SIZE_W-1:0] : trial[SIZE_W-1:0];
			quo_q <= {quo_q[W-2:0], ~neg};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
